[rtl/core/ahpt_pkg.sv]
package ahpt_pkg;

	localparam int unsigned DEF_TABLE_ENTRIES = 16;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned ETYPE_W  = 16;
	localparam int unsigned OPC_W    = 16;
	localparam int unsigned IP_W     = 32;
	localparam int unsigned MAC_W    = 48;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned TMO_W    = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Operation codes of an input word.
	localparam logic [OP_W-1:0] OP_FRAME   = 2'd0;
	localparam logic [OP_W-1:0] OP_CHECK   = 2'd1;
	localparam logic [OP_W-1:0] OP_PRELOAD = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_TIMEOUT = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_NOT_ARP    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_REPLY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OFF_SUBNET = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
	localparam logic [STATUS_W-1:0] ST_ENTRY      = 3'd6;
	localparam logic [STATUS_W-1:0] ST_CHECK_DONE = 3'd7;

	localparam logic [ETYPE_W-1:0] ETHERTYPE_ARP   = 16'h0806;
	localparam logic [OPC_W-1:0]   OPCODE_REPLY    = 16'd2;
	localparam logic [TIME_W-1:0]  SEED_AFTER      = 32'd120;
	localparam logic [TIME_W-1:0]  EVICT_AFTER     = 32'd1400000;
	localparam logic [TMO_W-1:0]   TIMEOUT_DEFAULT = 16'd300;

	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] seen;
		logic [TIME_W-1:0] probe;
	} entry_t;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_REJECT,
		EMIT_HIT,
		EMIT_INSERT,
		EMIT_FULL,
		EMIT_AGE,
		EMIT_DONE
	} emit_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_REFRESH,
		WR_INSERT,
		WR_AGE
	} wr_t;

	typedef struct packed {
		logic  load;
		logic  idx_clr;
		logic  idx_inc;
		logic  rd;
		logic  note_free;
		emit_t emit;
		wr_t   wr;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            reject;
		logic            cur_valid;
		logic            idx_last;
		logic            hit;
		logic            free_found;
		logic            age_act;
		logic            can_emit;
	} stat_t;

endpackage

[rtl/core/ahpt_ctrl.sv]
module ahpt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ahpt_pkg::stat_t st,
	output ahpt_pkg::cmd_t  cmd
);
	import ahpt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_REJECT,
		S_LK_SLOT,
		S_LK_EVAL,
		S_LK_HIT,
		S_LK_END,
		S_AG_SLOT,
		S_AG_EVAL,
		S_AG_EMIT,
		S_AG_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					case (st.op)
						OP_FRAME:   state_q <= st.reject ? S_REJECT : S_LK_SLOT;
						OP_CHECK:   state_q <= S_AG_SLOT;
						OP_PRELOAD: state_q <= S_LK_SLOT;
						default:    state_q <= S_IDLE;
					endcase
				end
				S_REJECT, S_LK_HIT, S_LK_END, S_AG_DONE: begin
					if (st.can_emit) state_q <= S_IDLE;
				end
				S_LK_SLOT: begin
					if (st.cur_valid) state_q <= S_LK_EVAL;
					else if (st.idx_last) state_q <= S_LK_END;
				end
				S_LK_EVAL: begin
					if (st.hit) state_q <= S_LK_HIT;
					else if (st.idx_last) state_q <= S_LK_END;
					else state_q <= S_LK_SLOT;
				end
				S_AG_SLOT: begin
					if (st.cur_valid) state_q <= S_AG_EVAL;
					else if (st.idx_last) state_q <= S_AG_DONE;
				end
				S_AG_EVAL: begin
					if (st.age_act) state_q <= S_AG_EMIT;
					else if (st.idx_last) state_q <= S_AG_DONE;
					else state_q <= S_AG_SLOT;
				end
				S_AG_EMIT: begin
					if (st.can_emit) state_q <= st.idx_last ? S_AG_DONE : S_AG_SLOT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '{load: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0, rd: 1'b0,
			note_free: 1'b0, emit: EMIT_NONE, wr: WR_NONE};
		case (state_q)
			S_IDLE: begin
				cmd.load    = in_valid;
				cmd.idx_clr = in_valid;
			end
			S_REJECT: begin
				if (st.can_emit) cmd.emit = EMIT_REJECT;
			end
			S_LK_SLOT: begin
				cmd.rd        = st.cur_valid;
				cmd.note_free = !st.cur_valid;
				cmd.idx_inc   = !st.cur_valid && !st.idx_last;
			end
			S_LK_EVAL: begin
				cmd.idx_inc = !st.hit && !st.idx_last;
			end
			S_LK_HIT: begin
				if (st.can_emit) begin
					cmd.emit = EMIT_HIT;
					cmd.wr   = WR_REFRESH;
				end
			end
			S_LK_END: begin
				if (st.can_emit) begin
					if (st.free_found) begin
						cmd.emit = EMIT_INSERT;
						cmd.wr   = WR_INSERT;
					end else begin
						cmd.emit = EMIT_FULL;
					end
				end
			end
			S_AG_SLOT: begin
				cmd.rd      = st.cur_valid;
				cmd.idx_inc = !st.cur_valid && !st.idx_last;
			end
			S_AG_EVAL: begin
				cmd.wr      = WR_AGE;
				cmd.idx_inc = !st.age_act && !st.idx_last;
			end
			S_AG_EMIT: begin
				if (st.can_emit) begin
					cmd.emit    = EMIT_AGE;
					cmd.idx_inc = !st.idx_last;
				end
			end
			S_AG_DONE: begin
				if (st.can_emit) cmd.emit = EMIT_DONE;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/ahpt_dp.sv]
module ahpt_dp #(
	parameter int unsigned TABLE_ENTRIES = ahpt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ahpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ahpt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [ahpt_pkg::OP_W-1:0]           operation,
	input  logic [ahpt_pkg::TIME_W-1:0]         now,
	input  logic [ahpt_pkg::ETYPE_W-1:0]        ether_type,
	input  logic [ahpt_pkg::OPC_W-1:0]          arp_opcode,
	input  logic [ahpt_pkg::IP_W-1:0]           sender_ip,
	input  logic [ahpt_pkg::MAC_W-1:0]          sender_mac,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ahpt_pkg::STATUS_W-1:0]       status,
	output logic [ahpt_pkg::SLOT_W-1:0]         slot,
	output logic [ahpt_pkg::IP_W-1:0]           host_address,
	output logic [ahpt_pkg::MAC_W-1:0]          host_hw_address,
	output logic                                probe_request,
	output logic                                evicted,
	output logic                                last,
	input  ahpt_pkg::cmd_t                      cmd,
	output ahpt_pkg::stat_t                     st
);
	import ahpt_pkg::*;

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(TABLE_ENTRIES - 1);

	logic [IP_W-1:0]    base_q;
	logic [IP_W-1:0]    mask_q;
	logic [TMO_W-1:0]   timeout_q;

	logic [OP_W-1:0]    op_q;
	logic [TIME_W-1:0]  now_q;
	logic [ETYPE_W-1:0] etype_q;
	logic [OPC_W-1:0]   opc_q;
	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;

	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   free_q;
	logic               free_found_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	entry_t             mem [TABLE_ENTRIES];
	entry_t             rd_q;

	logic [STATUS_W-1:0] reject_code;
	logic               reject;
	logic [TIME_W-1:0]  seen_new;
	logic signed [TIME_W:0] age_d;
	logic               probe_now;
	logic               evict_now;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			mask_q    <= '0;
			timeout_q <= TIMEOUT_DEFAULT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SUBNET_BASE:  base_q    <= cfg_data[IP_W-1:0];
				CFG_SUBNET_MASK:  mask_q    <= cfg_data[IP_W-1:0];
				CFG_HOST_TIMEOUT: timeout_q <= cfg_data[TMO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			now_q   <= now;
			etype_q <= ether_type;
			opc_q   <= arp_opcode;
			ip_q    <= sender_ip;
			mac_q   <= sender_mac;
		end
	end

	// Frame filter, checked in priority order.
	always_comb begin
		reject      = 1'b1;
		reject_code = ST_NOT_ARP;
		if (etype_q != ETHERTYPE_ARP) begin
			reject_code = ST_NOT_ARP;
		end else if (opc_q != OPCODE_REPLY) begin
			reject_code = ST_NOT_REPLY;
		end else if ((ip_q & mask_q) != base_q) begin
			reject_code = ST_OFF_SUBNET;
		end else begin
			reject = 1'b0;
		end
	end

	// Aging of rd_q. Zero seen is seeded before the difference if now_q > SEED_AFTER.
	always_comb begin
		seen_new = ((rd_q.seen == '0) && (now_q > SEED_AFTER)) ? now_q : rd_q.seen;
		age_d = $signed({1'b0, now_q}) - $signed({1'b0, seen_new});
		probe_now = (age_d > $signed({(TIME_W + 1 - TMO_W)'(0), timeout_q >> 1}))
			&& (rd_q.probe == '0);
		evict_now = (age_d > $signed({(TIME_W + 1 - TMO_W)'(0), timeout_q}))
			&& (now_q > EVICT_AFTER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			free_q       <= '0;
			free_found_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.load) begin
				free_found_q <= 1'b0;
			end else if (cmd.note_free && !free_found_q) begin
				free_found_q <= 1'b1;
				free_q       <= idx_q;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		case (cmd.wr)
			WR_REFRESH: begin
				wr_en        = (op_q == OP_FRAME);
				wr_data.seen = now_q;
			end
			WR_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = free_q;
				wr_data = '{ip: ip_q, mac: mac_q,
					seen: (op_q == OP_FRAME) ? now_q : '0, probe: '0};
			end
			WR_AGE: begin
				wr_en         = 1'b1;
				wr_data.seen  = seen_new;
				wr_data.probe = probe_now ? now_q : rd_q.probe;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr == WR_INSERT) begin
			valid_q[free_q] <= 1'b1;
		end else if ((cmd.wr == WR_AGE) && evict_now) begin
			valid_q[idx_q] <= 1'b0;
		end
	end

	// Output register: a new word may load while the previous one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EMIT_NONE) begin
			status          <= ST_CHECK_DONE;
			slot            <= '0;
			host_address    <= ip_q;
			host_hw_address <= mac_q;
			probe_request   <= 1'b0;
			evicted         <= 1'b0;
			last            <= 1'b1;
			case (cmd.emit)
				EMIT_REJECT: status <= reject_code;
				EMIT_HIT: begin
					status          <= ST_UPDATED;
					slot            <= SLOT_W'(idx_q);
					host_hw_address <= rd_q.mac;
				end
				EMIT_INSERT: begin
					status <= ST_INSERTED;
					slot   <= SLOT_W'(free_q);
				end
				EMIT_FULL: status <= ST_FULL;
				EMIT_AGE: begin
					status          <= ST_ENTRY;
					slot            <= SLOT_W'(idx_q);
					host_address    <= rd_q.ip;
					host_hw_address <= rd_q.mac;
					probe_request   <= probe_now;
					evicted         <= evict_now;
					last            <= 1'b0;
				end
				default: begin
					host_address    <= '0;
					host_hw_address <= '0;
				end
			endcase
		end
	end

	always_comb begin
		st.op         = op_q;
		st.reject     = reject;
		st.cur_valid  = valid_q[idx_q];
		st.idx_last   = (idx_q == IDX_MAX);
		st.hit        = (rd_q.ip == ip_q);
		st.free_found = free_found_q;
		st.age_act    = probe_now || evict_now;
		st.can_emit   = !out_valid || out_ready;
	end

endmodule

[rtl/core/arp_host_presence_table.sv]
// Channel  Handshake            Payload
// in       in_valid/in_ready    operation, now, ether_type, arp_opcode, sender_ip, sender_mac
// out      out_valid/out_ready  status, slot, host_address, host_hw_address, probe_request,
//                               evicted, last
// cfg      cfg_wr_en            cfg_index, cfg_data (write only, no wait)
//
// One input word is worked on at a time; the table is a single-port memory walked
// one free slot per cycle, each occupied slot taking a read state, then a compare state.
// A frame that passes the filter, or a preload, walks the table until a hit or its end;
// a check walks every slot; any may also wait on out_ready before its result is emitted.
// Reset clears the valid bits at once; no clearing pass is needed.
// Entry results stall in place while the output register is full.
module arp_host_presence_table #(
	parameter int unsigned TABLE_ENTRIES = ahpt_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ahpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ahpt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ahpt_pkg::OP_W-1:0]           operation,
	input  logic [ahpt_pkg::TIME_W-1:0]         now,
	input  logic [ahpt_pkg::ETYPE_W-1:0]        ether_type,
	input  logic [ahpt_pkg::OPC_W-1:0]          arp_opcode,
	input  logic [ahpt_pkg::IP_W-1:0]           sender_ip,
	input  logic [ahpt_pkg::MAC_W-1:0]          sender_mac,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ahpt_pkg::STATUS_W-1:0]       status,
	output logic [ahpt_pkg::SLOT_W-1:0]         slot,
	output logic [ahpt_pkg::IP_W-1:0]           host_address,
	output logic [ahpt_pkg::MAC_W-1:0]          host_hw_address,
	output logic                                probe_request,
	output logic                                evicted,
	output logic                                last
);
	import ahpt_pkg::*;

	cmd_t  cmd;
	stat_t st;

	ahpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	ahpt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.now             (now),
		.ether_type      (ether_type),
		.arp_opcode      (arp_opcode),
		.sender_ip       (sender_ip),
		.sender_mac      (sender_mac),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot            (slot),
		.host_address    (host_address),
		.host_hw_address (host_hw_address),
		.probe_request   (probe_request),
		.evicted         (evicted),
		.last            (last),
		.cmd             (cmd),
		.st              (st)
	);

endmodule
